// File: design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared request and response types and command codes for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam int CAP_WIDTH = 5;

   typedef struct packed {
      logic        command;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
   } rsp_type;

endpackage

// File: design/lfu_if.sv
// ----------------------------------------------------------------------------
// LFU cache channel interfaces
// Valid/ready channels for requests, responses and the capacity register.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lfu_csr_if import lfu_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CAP_WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/lfu_cache_table.sv
// Each request goes through the idle, match and execute states; a put that
// evicts also scans the table for a victim first, one line per cycle.
// A new request is taken only in idle, once any response has been accepted.
// A two-entry request queue decouples intake from the table engine.
// Reset (synchronous) invalidates all lines and sets capacity to 16.
// ----------------------------------------------------------------------------
// LFU cache table top level
// LFU key/value cache with LRU tie break, capacity register and a request queue.
// ----------------------------------------------------------------------------
module lfu_cache_table import lfu_pkg::*; #(
   parameter int ENTRIES     = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req,
   lfu_rsp_if.source rsp,
   lfu_csr_if.sink   csr
);

   logic [CAP_WIDTH-1:0] cap_ff;
   logic                 q_valid, q_pop;
   req_type              q_data;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_WIDTH'(16);
      end else if (csr.valid) begin
         cap_ff <= csr.data;
      end
   end

   lfu_front u_front (
      .clock, .reset, .req, .q_valid, .q_pop, .q_data
   );

   lfu_back #(.ENTRIES(ENTRIES), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data, .cap_raw(cap_ff), .rsp
   );

endmodule

// File: design/lfu_front.sv
// ----------------------------------------------------------------------------
// LFU cache front end
// Accepts requests into a two-entry queue toward the table engine.
// ----------------------------------------------------------------------------
module lfu_front import lfu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   lfu_req_if.sink req,
   output logic    q_valid,
   input  logic    q_pop,
   output req_type q_data
);

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (q_pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = req.payload;
         cnt_in             = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !q_pop) |=> cnt_ff == 2'd2) else $error("queue lost entry");

endmodule

// File: design/lfu_back.sv
// ----------------------------------------------------------------------------
// LFU cache table engine
// Register table with parallel key match and a registered victim search.
// ----------------------------------------------------------------------------
module lfu_back import lfu_pkg::*; #(
   parameter int ENTRIES     = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  req_type              q_data,
   input  logic [CAP_WIDTH-1:0] cap_raw,
   lfu_rsp_if.source            rsp
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_MATCH = 4'b0010, S_SCAN = 4'b0100, S_EXEC = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [31:0]            key_ff   [ENTRIES];
   logic [31:0]            val_ff   [ENTRIES];
   logic [COUNT_WIDTH-1:0] cnt_ff   [ENTRIES];
   logic [IW-1:0]          rank_ff  [ENTRIES];
   logic [31:0]            key_in   [ENTRIES];
   logic [31:0]            val_in   [ENTRIES];
   logic [COUNT_WIDTH-1:0] cnt_in   [ENTRIES];
   logic [IW-1:0]          rank_in  [ENTRIES];
   req_type                cur_ff, cur_in;
   logic                   hit_ff, hit_in;
   logic [IW-1:0]          hidx_ff, hidx_in;
   logic [OW-1:0]          occ_ff, occ_in;
   logic [IW-1:0]          scan_ff, scan_in;
   logic                   vok_ff, vok_in;
   logic [IW-1:0]          vidx_ff, vidx_in;
   logic                   ovalid_ff, ovalid_in;
   rsp_type                odata_ff, odata_in;
   logic [OW-1:0]          cap;

   assign cap         = (32'(cap_raw) > 32'(ENTRIES)) ? OW'(ENTRIES) : OW'(cap_raw);
   assign rsp.valid   = ovalid_ff;
   assign rsp.payload = odata_ff;

   always_comb begin
      logic          ev;
      logic [IW-1:0] tgt;
      logic          fnd;
      logic [IW-1:0] tr;
      state_in  = state_ff;
      valid_in  = valid_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      rank_in   = rank_ff;
      cur_in    = cur_ff;
      hit_in    = hit_ff;
      hidx_in   = hidx_ff;
      occ_in    = occ_ff;
      scan_in   = scan_ff;
      vok_in    = vok_ff;
      vidx_in   = vidx_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      odata_in  = odata_ff;
      q_pop     = 1'b0;
      ev        = 1'b0;
      tgt       = '0;
      fnd       = 1'b0;
      tr        = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !ovalid_in) begin
               q_pop    = 1'b1;
               cur_in   = q_data;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            hit_in  = 1'b0;
            hidx_in = '0;
            occ_in  = '0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && key_ff[i] == cur_ff.key) begin
                  hit_in  = 1'b1;
                  hidx_in = IW'(i);
               end
               occ_in = occ_in + OW'(valid_ff[i]);
            end
            scan_in  = '0;
            vok_in   = 1'b0;
            vidx_in  = '0;
            state_in = (cur_ff.command == CMD_PUT && !hit_in && occ_in >= cap
                        && cap != '0) ? S_SCAN : S_EXEC;
         end
         S_SCAN: begin
            if (valid_ff[scan_ff] && (!vok_ff || cnt_ff[scan_ff] < cnt_ff[vidx_ff] ||
                (cnt_ff[scan_ff] == cnt_ff[vidx_ff] &&
                 rank_ff[scan_ff] > rank_ff[vidx_ff]))) begin
               vok_in  = 1'b1;
               vidx_in = scan_ff;
            end
            scan_in = scan_ff + IW'(1);
            if (32'(scan_ff) == ENTRIES - 1) state_in = S_EXEC;
         end
         default: begin
            state_in = S_IDLE;
            if (cur_ff.command == CMD_GET || (cap != '0 && hit_ff)) begin
               if (hit_ff) begin
                  tr = rank_ff[hidx_ff];
                  for (int i = 0; i < ENTRIES; i++)
                     if (valid_ff[i] && rank_ff[i] < tr) rank_in[i] = rank_ff[i] + IW'(1);
                  rank_in[hidx_ff] = '0;
                  if (cnt_ff[hidx_ff] != CMAX)
                     cnt_in[hidx_ff] = cnt_ff[hidx_ff] + COUNT_WIDTH'(1);
                  if (cur_ff.command == CMD_PUT) val_in[hidx_ff] = cur_ff.value;
               end
               if (cur_ff.command == CMD_GET) begin
                  ovalid_in           = 1'b1;
                  odata_in.hit        = hit_ff;
                  odata_in.read_value = hit_ff ? val_ff[hidx_ff] : 32'd0;
               end
            end else if (cap != '0) begin
               if (occ_ff >= cap) begin
                  ev  = vok_ff;
                  tgt = vidx_ff;
                  fnd = vok_ff;
               end else begin
                  for (int i = ENTRIES - 1; i >= 0; i--)
                     if (!valid_ff[i]) begin
                        tgt = IW'(i);
                        fnd = 1'b1;
                     end
               end
               if (fnd) begin
                  tr = rank_ff[tgt];
                  for (int i = 0; i < ENTRIES; i++)
                     if (valid_ff[i] && IW'(i) != tgt && !(ev && rank_ff[i] > tr))
                        rank_in[i] = rank_ff[i] + IW'(1);
                  valid_in[tgt] = 1'b1;
                  key_in[tgt]   = cur_ff.key;
                  val_in[tgt]   = cur_ff.value;
                  cnt_in[tgt]   = COUNT_WIDTH'(1);
                  rank_in[tgt]  = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      val_ff   <= val_in;
      cnt_ff   <= cnt_in;
      rank_ff  <= rank_in;
      cur_ff   <= cur_in;
      hit_ff   <= hit_in;
      hidx_ff  <= hidx_in;
      occ_ff   <= occ_in;
      scan_ff  <= scan_in;
      vok_ff   <= vok_in;
      vidx_ff  <= vidx_in;
      odata_ff <= odata_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && cur_ff.command == CMD_PUT && !hit_ff && cap != '0
       && occ_ff >= cap) |-> vok_ff) else $error("no victim found");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp.ready) |=> ovalid_ff && $stable(odata_ff))
      else $error("response dropped");

endmodule

// File: tb/tb_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// LFU cache table testbench
// Drives get and put requests and capacity writes through the valid/ready
// channels. Every get response is compared against a behavioral model of the
// LFU table with LRU tie break. A directed table comes first, then random
// traffic over small key pools, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import lfu_pkg::*;

   localparam int LINES      = 16;
   localparam int CNT_MAX    = 65535;
   localparam int RAND_ITEMS = 1500;

   typedef struct {
      logic        command;
      logic [31:0] key;
      logic [31:0] value;
      logic        check;
      logic        hit;
      logic [31:0] read_value;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfu_req_if req ();
   lfu_rsp_if rsp ();
   lfu_csr_if csr ();

   lfu_cache_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #1 clock = ~clock;

   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

   // model state
   logic        m_valid [LINES];
   logic [31:0] m_key   [LINES];
   logic [31:0] m_value [LINES];
   int unsigned m_count [LINES];
   int unsigned m_rank  [LINES];
   int unsigned m_cap;

   rsp_type     lookup_q [$];
   logic        known_q  [$];
   rsp_type     given_q  [$];

   int  errors;
   int  gets_seen;
   int  puts_sent;
   int  send_idle;
   int  recv_idle;
   logic [31:0] key_pool [8];

   function automatic int find_line(logic [31:0] k);
      for (int i = 0; i < LINES; i++)
         if (m_valid[i] && m_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void touch_line(int idx);
      for (int i = 0; i < LINES; i++)
         if (m_valid[i] && i != idx && m_rank[i] < m_rank[idx]) m_rank[i]++;
      m_rank[idx] = 0;
      if (m_count[idx] < CNT_MAX) m_count[idx]++;
   endfunction

   function automatic rsp_type cache_step(logic cmd, logic [31:0] k, logic [31:0] v,
                                          output logic gives);
      rsp_type r;
      int idx;
      int occ;
      int cap;
      r = '0;
      gives = 1'b0;
      cap = (m_cap > LINES) ? LINES : m_cap;
      idx = find_line(k);
      if (cmd == CMD_GET) begin
         gives = 1'b1;
         if (idx >= 0) begin
            touch_line(idx);
            r.hit = 1'b1;
            r.read_value = m_value[idx];
         end
         return r;
      end
      if (cap == 0) return r;
      if (idx >= 0) begin
         m_value[idx] = v;
         touch_line(idx);
         return r;
      end
      occ = 0;
      foreach (m_valid[i]) if (m_valid[i]) occ++;
      if (occ >= cap) begin
         for (int i = 0; i < LINES; i++) begin
            if (!m_valid[i]) continue;
            if (idx < 0 || m_count[i] < m_count[idx] ||
                (m_count[i] == m_count[idx] && m_rank[i] > m_rank[idx])) idx = i;
         end
         for (int i = 0; i < LINES; i++)
            if (m_valid[i] && i != idx && m_rank[i] > m_rank[idx]) m_rank[i]--;
         m_valid[idx] = 1'b0;
      end else begin
         for (int i = LINES - 1; i >= 0; i--) if (!m_valid[i]) idx = i;
      end
      for (int i = 0; i < LINES; i++) if (m_valid[i]) m_rank[i]++;
      m_valid[idx] = 1'b1;
      m_key[idx]   = k;
      m_value[idx] = v;
      m_count[idx] = 1;
      m_rank[idx]  = 0;
      return r;
   endfunction

   // valid stays high after a request; idling, drain and capacity writes drop it
   task automatic send_request(logic cmd, logic [31:0] k, logic [31:0] v,
                               logic check, rsp_type want);
      rsp_type pred;
      logic gives;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= '{command: cmd, key: k, value: v};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pred = cache_step(cmd, k, v, gives);
      if (gives) begin
         if (check && pred != want) begin
            $error("directed row disagrees with model for key %h", k);
            errors++;
         end
         lookup_q.push_back(check ? want : pred);
      end else begin
         puts_sent++;
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (lookup_q.size() > 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3 * (3 + LINES)) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned cap);
      drain();
      csr.valid <= 1'b1;
      csr.data  <= cap[CAP_WIDTH-1:0];
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      m_cap = cap;
   endtask

   // response side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (lookup_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               rsp_type e;
               e = lookup_q.pop_front();
               gets_seen++;
               if (rsp.payload.hit !== e.hit) begin
                  $error("hit: expected %0d actual %0d", e.hit, rsp.payload.hit);
                  errors++;
               end
               if (rsp.payload.read_value !== e.read_value) begin
                  $error("read_value: expected %h actual %h", e.read_value,
                         rsp.payload.read_value);
                  errors++;
               end
            end
         end
         rsp.ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      end
   end

   step_type dir [] = '{
      '{CMD_GET, 32'h0000_0000, 32'h0,         1, 0, 32'h0},
      '{CMD_GET, 32'h8000_0000, 32'h0,         1, 0, 32'h0},
      '{CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h0},
      '{CMD_GET, 32'h8000_0000, 32'h0,         1, 1, 32'h7FFF_FFFF},
      '{CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h0},
      '{CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000},
      '{CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0},
      '{CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 32'h0},
      '{CMD_GET, 32'hFFFF_FFFF, 32'h0,         1, 1, 32'h0},
      '{CMD_GET, 32'h0000_0001, 32'h0,         1, 0, 32'h0}
   };

   initial begin
      int cap_list [6];
      int n;
      int pick;
      logic [31:0] k;
      cap_list = '{16, 31, 1, 3, 0, 8};
      errors = 0; gets_seen = 0; puts_sent = 0;
      send_idle = 0; recv_idle = 0;
      req.valid = 1'b0; req.payload = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.data = '0;
      foreach (m_valid[i]) begin
         m_valid[i] = 0; m_key[i] = 0; m_value[i] = 0; m_count[i] = 0; m_rank[i] = 0;
      end
      m_cap = 16;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i])
         send_request(dir[i].command, dir[i].key, dir[i].value, dir[i].check,
                      '{hit: dir[i].hit, read_value: dir[i].read_value});
      // fill, then force evictions with ties and a hot line
      for (int i = 0; i < 18; i++) begin
         send_request(CMD_PUT, 32'h100 + i, i, 0, '0);
         if (i == 2) send_request(CMD_GET, 32'h100, 0, 0, '0);
      end
      write_capacity(0);
      send_request(CMD_PUT, 32'h100, 32'h5555_AAAA, 0, '0);
      send_request(CMD_GET, 32'h100, 0, 0, '0);
      write_capacity(2);
      send_request(CMD_PUT, 32'h200, 1, 0, '0);
      send_request(CMD_GET, 32'h200, 0, 0, '0);
      // hammer one line, then replace it with capacity one
      write_capacity(1);
      send_request(CMD_PUT, 32'h300, 7, 0, '0);
      for (int i = 0; i < 20; i++)
         send_request(CMD_GET, 32'h300, 0, 0, '0);
      send_request(CMD_PUT, 32'h301, 8, 0, '0);
      send_request(CMD_GET, 32'h300, 0, 0, '0);

      n = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 10 : (ph == 1) ? 68 : 0;
         recv_idle = (ph == 0) ? 68 : (ph == 1) ? 10 : 0;
         for (int c = 0; c < 6; c++) begin
            write_capacity(cap_list[(c + ph) % 6]);
            foreach (key_pool[i])
               key_pool[i] = ($urandom_range(3) == 0) ? $urandom() : 32'h10 + i + 8 * c;
            for (int i = 0; i < RAND_ITEMS / 18; i++) begin
               pick = $urandom_range(7);
               k = ($urandom_range(15) == 0) ? $urandom() : key_pool[pick];
               send_request(1'($urandom_range(1)), k, $urandom(), 0, '0);
               n++;
            end
         end
      end
      drain();
      $display("Ran %0d random requests, %0d responses checked, %0d puts, capacities 0..31.",
               n, gets_seen, puts_sent);
      if (errors == 0 && lookup_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
